/* rtl/imu_afd_pkg.sv */
// ----------------------------------------------------------------------------
// imu_afd_pkg
// Shared types and constants for the IMU activity / fall detector.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_afd_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_ROOT  = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_FIN   = 5'b10000
  } afd_state_t;

  // Configuration register indexes
  localparam logic [1:0] REG_IMPACT_THR = 2'd0;
  localparam logic [1:0] REG_STILLNESS  = 2'd1;
  localparam logic [1:0] REG_STEP_GAP   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  IMPACT_THR_RST = 8'd30;
  localparam logic [31:0] STILLNESS_RST  = 32'd30000;
  localparam logic [15:0] STEP_GAP_RST   = 16'd500;

  // Activity codes
  localparam logic [2:0] ACT_SIT   = 3'd0;
  localparam logic [2:0] ACT_WALK  = 3'd1;
  localparam logic [2:0] ACT_LIE   = 3'd2;
  localparam logic [2:0] ACT_STAND = 3'd3;
  localparam logic [2:0] ACT_FIDGET = 3'd4;
  localparam logic [2:0] ACT_FALL  = 3'd5;

  // Multiply-accumulate steps of the shared multiplier
  localparam logic [2:0] MAC_AX   = 3'd0;
  localparam logic [2:0] MAC_AY   = 3'd1;
  localparam logic [2:0] MAC_AZ   = 3'd2;
  localparam logic [2:0] MAC_RX   = 3'd3;
  localparam logic [2:0] MAC_RY   = 3'd4;
  localparam logic [2:0] MAC_RZ   = 3'd5;
  localparam logic [2:0] MAC_THR  = 3'd6;
  localparam logic [2:0] MAC_THR2 = 3'd7;

  // Squared acceleration thresholds (mg^2)
  localparam logic [31:0] A2_LIE_MAX   = 32'd250000;   // 0.5 g
  localparam logic [31:0] A2_SIT_MIN   = 32'd640000;   // 0.8 g
  localparam logic [31:0] A2_STAND_MIN = 32'd810000;   // 0.9 g
  localparam logic [31:0] A2_STAND_MAX = 32'd1210000;  // 1.1 g
  localparam logic [31:0] A2_WALK_MIN  = 32'd1440000;  // 1.2 g
  localparam logic [31:0] A2_MOVE_MIN  = 32'd90000;    // 0.3 g
  localparam logic [31:0] A2_MOVE_MAX  = 32'd2250000;  // 1.5 g

  // Squared rate thresholds
  localparam logic [33:0] G2_STAND_MAX = 34'd90000;
  localparam logic [33:0] G2_LOW       = 34'd250000;
  localparam logic [33:0] G2_HIGH      = 34'd4000000;

  // Tenths-of-g scaling: x/100 as (x*5243)>>19, exact below the saturation point
  localparam logic [16:0] TENTH_SCALE  = 17'd100;
  localparam logic [16:0] DIV100_RECIP = 17'd5243;
  localparam logic [15:0] ROOT_SAT     = 16'd25600;
  localparam logic [7:0]  LEVEL_MAX    = 8'd255;

  // Digit-by-digit square root of a 32-bit radicand
  localparam int unsigned ROOT_STEPS = 16;

endpackage

`default_nettype wire

/* rtl/imu_activity_fall_detector_core.sv */
// ----------------------------------------------------------------------------
// imu_activity_fall_detector_core
// Activity classifier and fall detector for one IMU sample per request.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  in_*     | slave     | in_tdata: accel x/y/z, rate x/y/z, time_ms
//  out_*    | master    | out_tdata: activity, alert, armed, impact_x10, steps
//  cfg_*    | write     | cfg_index selects threshold, stillness or step gap
//
//  A sample passes from acceptance to result through the shared 17x17
//  multiplier (squares, threshold), the square-root unit, the tenths-of-g
//  scaling on the multiplier and a final state that updates and emits.
//  in_tready is high only while the sequencer is idle, so the next request
//  is taken in the cycle after the result at the earliest.
//  A result waits in the output register; a stalled output holds the
//  sequencer in its final state until the slot frees.
//  Reset is synchronous, active low, and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_activity_fall_detector_core
  import imu_afd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // ax[15:0] ay[31:16] az[47:32] rx[64:48] ry[81:65] rz[98:82] time_ms[130:99]
  input  wire logic [135:0] in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // activity[2:0] fall_alert[3] fall_armed[4] impact_x10[12:5] steps[28:13]
  output logic [31:0]       out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);

  // configuration
  logic [7:0]  imp_thr_r;
  logic [31:0] still_r;
  logic [15:0] gap_r;

  // sequencer
  afd_state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  // captured sample
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [16:0] rx_r, ry_r, rz_r;
  logic [31:0]        now_r;

  // working registers
  logic [31:0] a2_r;
  logic [33:0] g2_r;
  logic [14:0] thr_r;
  logic [29:0] thr2_r;
  logic [15:0] root_r;
  logic [7:0]  lvl_r;

  // detector state
  logic        armed_r;
  logic [31:0] impact_time_r, movement_time_r, step_time_r;
  logic [15:0] steps_r;
  logic [7:0]  impact_level_r;

  // output register
  logic [31:0] out_data_r;
  logic        out_valid_r;

  // shared multiplier
  logic signed [16:0] op_a, op_b;
  logic signed [33:0] prod;

  logic        in_acc;
  logic        fin_go;
  logic        root_start;
  logic        root_done;
  logic [15:0] root_w;

  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign root_start = (state_r == ST_MAC) && (step_r == MAC_THR2);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imp_thr_r <= IMPACT_THR_RST;
      still_r   <= STILLNESS_RST;
      gap_r     <= STEP_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMPACT_THR: imp_thr_r <= cfg_wdata[7:0];
        REG_STILLNESS:  still_r   <= cfg_wdata;
        REG_STEP_GAP:   gap_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == ST_SCALE) begin
      op_a = signed'({1'b0, root_r});
      op_b = signed'(DIV100_RECIP);
    end else begin
      case (step_r)
        MAC_AX:   begin op_a = {ax_r[15], ax_r}; op_b = {ax_r[15], ax_r}; end
        MAC_AY:   begin op_a = {ay_r[15], ay_r}; op_b = {ay_r[15], ay_r}; end
        MAC_AZ:   begin op_a = {az_r[15], az_r}; op_b = {az_r[15], az_r}; end
        MAC_RX:   begin op_a = rx_r; op_b = rx_r; end
        MAC_RY:   begin op_a = ry_r; op_b = ry_r; end
        MAC_RZ:   begin op_a = rz_r; op_b = rz_r; end
        MAC_THR:  begin op_a = signed'({9'd0, imp_thr_r}); op_b = signed'(TENTH_SCALE); end
        default:  begin op_a = signed'({2'b0, thr_r}); op_b = signed'({2'b0, thr_r}); end
      endcase
    end
  end

  assign prod = op_a * op_b;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = MAC_AX;
        if (in_acc) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        step_nxt = step_r + 3'd1;
        if (step_r == MAC_THR2) state_nxt = ST_ROOT;
      end
      ST_ROOT:  if (root_done) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= MAC_AX;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r  <= signed'(in_tdata[15:0]);
      ay_r  <= signed'(in_tdata[31:16]);
      az_r  <= signed'(in_tdata[47:32]);
      rx_r  <= signed'(in_tdata[64:48]);
      ry_r  <= signed'(in_tdata[81:65]);
      rz_r  <= signed'(in_tdata[98:82]);
      now_r <= in_tdata[130:99];
    end
  end

  // multiply-accumulate of squares and threshold
  always_ff @(posedge clk) begin
    if (state_r == ST_MAC) begin
      case (step_r)
        MAC_AX:         a2_r <= prod[31:0];
        MAC_AY, MAC_AZ: a2_r <= a2_r + prod[31:0];
        MAC_RX:         g2_r <= unsigned'(prod);
        MAC_RY, MAC_RZ: g2_r <= g2_r + unsigned'(prod);
        MAC_THR:        thr_r <= prod[14:0];
        default:        thr2_r <= prod[29:0];
      endcase
    end
  end

  // square root of the squared acceleration magnitude
  imu_afd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (a2_r),
    .done     (root_done),
    .root     (root_w)
  );

  always_ff @(posedge clk) begin
    if ((state_r == ST_ROOT) && root_done) root_r <= root_w;
    if (state_r == ST_SCALE) lvl_r <= (root_r >= ROOT_SAT) ? LEVEL_MAX : prod[26:19];
  end

  // classification and fall rules
  logic [2:0]  cls;
  logic [2:0]  act;
  logic        impact, moving, check, still_ok, alert, armed_new, step_hit;
  logic [31:0] imp_age, mov_age, step_age;
  logic [15:0] steps_new;
  logic [7:0]  level_new;

  always_comb begin
    if (g2_r > G2_HIGH && a2_r > A2_WALK_MIN)
      cls = ACT_WALK;
    else if (a2_r < A2_LIE_MAX)
      cls = ACT_LIE;
    else if (a2_r > A2_SIT_MIN && a2_r < A2_WALK_MIN && g2_r < G2_LOW)
      cls = ACT_SIT;
    else if (a2_r > A2_STAND_MIN && a2_r < A2_STAND_MAX && g2_r < G2_STAND_MAX)
      cls = ACT_STAND;
    else if (g2_r > G2_LOW && g2_r < G2_HIGH)
      cls = ACT_FIDGET;
    else
      cls = ACT_SIT;

    impact   = a2_r > {2'b0, thr2_r};
    moving   = (a2_r > A2_MOVE_MIN) && (a2_r < A2_MOVE_MAX);
    imp_age  = now_r - impact_time_r;
    mov_age  = now_r - movement_time_r;
    step_age = now_r - step_time_r;
    // a fresh impact or fresh movement has age zero and never passes
    check    = armed_r && !impact && (imp_age > still_r);
    still_ok = !moving && (mov_age > still_r);
    alert    = check && still_ok;
    armed_new = impact || (armed_r && !(check && !still_ok));
    act      = alert ? ACT_FALL : cls;
    step_hit = (act == ACT_WALK) && (step_age > {16'd0, gap_r});
    steps_new = step_hit ? steps_r + 16'd1 : steps_r;
    level_new = impact ? lvl_r : impact_level_r;
  end

  // detector state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r         <= 1'b0;
      impact_time_r   <= '0;
      movement_time_r <= '0;
      step_time_r     <= '0;
      steps_r         <= '0;
      impact_level_r  <= '0;
    end else if (fin_go) begin
      armed_r        <= armed_new;
      steps_r        <= steps_new;
      impact_level_r <= level_new;
      if (impact)   impact_time_r   <= now_r;
      if (moving)   movement_time_r <= now_r;
      if (step_hit) step_time_r     <= now_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) out_data_r <= {3'd0, steps_new, level_new, armed_new, alert, act};
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // checks
  a_emit_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

  a_alert_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3]) |-> (out_tdata[4] && (out_tdata[2:0] == ACT_FALL)))
    else $error("fall alert without armed flag or fall activity");

  a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == ST_ROOT))
    else $error("square root finished outside its wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MAC) && (step_r == MAC_AX))
    else $error("accepted request did not start the sequence");

endmodule

`default_nettype wire

/* rtl/imu_afd_isqrt.sv */
// ----------------------------------------------------------------------------
// imu_afd_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_afd_isqrt
  import imu_afd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic [15:0]      root
);

  logic [31:0] n_r, n_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // one restoring step per cycle
  always_comb begin
    n_nxt    = n_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {1'b0, r_r} + {1'b0, bit_r};
    if (start) begin
      n_nxt    = radicand;
      r_nxt    = '0;
      bit_nxt  = 32'h4000_0000;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_nxt = n_r - trial[31:0];
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(ROOT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[15:0];

endmodule

`default_nettype wire

/* sim/imu_afd_checker.sv */
// ----------------------------------------------------------------------------
// imu_afd_checker
// Watches the sample, status and register-write channels of the activity /
// fall detector, predicts each status from its own copy of the classifier
// and fall state, and compares it field by field against what comes out.
// ----------------------------------------------------------------------------

module imu_afd_checker
  import imu_afd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // ax[15:0] ay[31:16] az[47:32] rx[64:48] ry[81:65] rz[98:82] time_ms[130:99]
  input  wire logic [135:0] in_tdata,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // activity[2:0] fall_alert[3] fall_armed[4] impact_x10[12:5] steps[28:13]
  input  wire logic [31:0]  out_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Status word, most significant field first so it overlays out_tdata[28:0]
  typedef struct packed {
    logic [15:0] steps;
    logic [7:0]  impact_x10;
    logic        armed;
    logic        alert;
    logic [2:0]  activity;
  } afd_status_t;

  // Register values after reset
  localparam logic [7:0]  THR_AT_RESET   = 8'd30;
  localparam logic [31:0] STILL_AT_RESET = 32'd30000;
  localparam logic [15:0] GAP_AT_RESET   = 16'd500;

  // Squared magnitude bands, mg^2 for accel and milli-units^2 for rate
  localparam longint unsigned ACC2_LYING_BELOW = 250000;
  localparam longint unsigned ACC2_SIT_ABOVE   = 640000;
  localparam longint unsigned ACC2_STAND_ABOVE = 810000;
  localparam longint unsigned ACC2_STAND_BELOW = 1210000;
  localparam longint unsigned ACC2_WALK_ABOVE  = 1440000;
  localparam longint unsigned ACC2_MOVE_ABOVE  = 90000;
  localparam longint unsigned ACC2_MOVE_BELOW  = 2250000;
  localparam longint unsigned RATE2_STAND      = 90000;
  localparam longint unsigned RATE2_CALM       = 250000;
  localparam longint unsigned RATE2_BRISK      = 4000000;

  // Configuration copy
  logic [7:0]  impact_thr;
  logic [31:0] still_ms;
  logic [15:0] gap_ms;

  // Fall and step state copy
  logic        armed;
  logic [31:0] impact_time;
  logic [31:0] movement_time;
  logic [31:0] step_time;
  logic [15:0] step_count;
  logic [7:0]  impact_level;

  afd_status_t expected_status_q[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic longint unsigned sum_of_squares(longint a, longint b, longint c);
    return a * a + b * b + c * c;
  endfunction

  // Largest r with r*r <= n, one bit at a time from the top
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned trial;
    int b;
    r = 0;
    for (b = 20; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= n) r = trial;
    end
    return r;
  endfunction

  // First matching band wins; standing sits inside the sitting band
  function automatic logic [2:0] classify_activity(longint unsigned acc2,
                                                   longint unsigned rate2);
    if (rate2 > RATE2_BRISK && acc2 > ACC2_WALK_ABOVE) return ACT_WALK;
    if (acc2 < ACC2_LYING_BELOW) return ACT_LIE;
    if (acc2 > ACC2_SIT_ABOVE && acc2 < ACC2_WALK_ABOVE && rate2 < RATE2_CALM)
      return ACT_SIT;
    if (acc2 > ACC2_STAND_ABOVE && acc2 < ACC2_STAND_BELOW && rate2 < RATE2_STAND)
      return ACT_STAND;
    if (rate2 > RATE2_CALM && rate2 < RATE2_BRISK) return ACT_FIDGET;
    return ACT_SIT;
  endfunction

  // Advance the fall/step state by one sample and return its status
  function automatic afd_status_t predict_status(logic [135:0] d);
    longint unsigned acc2;
    longint unsigned rate2;
    longint unsigned thr;
    longint unsigned level;
    logic [31:0] now;
    afd_status_t r;
    acc2  = sum_of_squares($signed(d[15:0]), $signed(d[31:16]), $signed(d[47:32]));
    rate2 = sum_of_squares($signed(d[64:48]), $signed(d[81:65]), $signed(d[98:82]));
    now   = d[130:99];
    thr   = impact_thr * 100;
    r.activity = classify_activity(acc2, rate2);
    r.alert    = 1'b0;

    // impact arms the fall and latches its size in tenths of g
    if (acc2 > thr * thr) begin
      level        = root_floor(acc2) / 100;
      impact_level = (level > 255) ? 8'd255 : level[7:0];
      impact_time  = now;
      armed        = 1'b1;
    end
    if (acc2 > ACC2_MOVE_ABOVE && acc2 < ACC2_MOVE_BELOW) movement_time = now;

    // past the stillness window: confirm if still, else cancel
    if (armed && (now - impact_time) > still_ms) begin
      if ((now - movement_time) > still_ms) begin
        r.activity = ACT_FALL;
        r.alert    = 1'b1;
      end else begin
        armed = 1'b0;
      end
    end
    if (r.activity == ACT_WALK && (now - step_time) > {16'd0, gap_ms}) begin
      step_count = step_count + 16'd1;
      step_time  = now;
    end

    r.armed      = armed;
    r.impact_x10 = impact_level;
    r.steps      = step_count;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    afd_status_t got;
    afd_status_t want;
    if (!rst_n) begin
      impact_thr    = THR_AT_RESET;
      still_ms      = STILL_AT_RESET;
      gap_ms        = GAP_AT_RESET;
      armed         = 1'b0;
      impact_time   = '0;
      movement_time = '0;
      step_time     = '0;
      step_count    = '0;
      impact_level  = '0;
      expected_status_q.delete();
    end else begin
      // register writes; an unused index changes nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_IMPACT_THR: impact_thr = cfg_wdata[7:0];
          REG_STILLNESS:  still_ms   = cfg_wdata;
          REG_STEP_GAP:   gap_ms     = cfg_wdata[15:0];
          default: ;
        endcase
      end

      // status request: compare against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata[28:0];
        if (expected_status_q.size() == 0) begin
          report_mismatch("status with no sample outstanding", got, 0);
        end else begin
          want = expected_status_q.pop_front();
          if (got.activity !== want.activity)
            report_mismatch("activity", got.activity, want.activity);
          if (got.alert !== want.alert)
            report_mismatch("fall_alert", got.alert, want.alert);
          if (got.armed !== want.armed)
            report_mismatch("fall_armed", got.armed, want.armed);
          if (got.impact_x10 !== want.impact_x10)
            report_mismatch("impact_x10", got.impact_x10, want.impact_x10);
          if (got.steps !== want.steps)
            report_mismatch("steps", got.steps, want.steps);
        end
      end

      // sample request
      if (in_tvalid && in_tready) expected_status_q.push_back(predict_status(in_tdata));
    end
    pending = expected_status_q.size();
  end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives IMU samples into the activity / fall detector: a directed opening
// over the bands, impacts, confirmation, cancelling and timestamp wrap, then
// random walking, fall and noise sequences under several register settings
// and idling patterns. The checker beside the block judges every status.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imu_afd_pkg::*;

  // Index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum {
    SHAPE_NOISE, SHAPE_STILL, SHAPE_LYING, SHAPE_UPRIGHT,
    SHAPE_FIDGET, SHAPE_WALK, SHAPE_IMPACT
  } motion_t;

  logic         clk;
  logic         rst_n;
  logic [135:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  int           mismatches;
  int           pending;

  int           send_idle_pct;
  int           recv_stall_pct;
  int           sent;
  logic [31:0]  clock_ms;
  logic [7:0]   cur_thr;
  logic [31:0]  cur_still;
  logic [15:0]  cur_gap;

  imu_activity_fall_detector_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  imu_afd_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int signed_mag(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return $urandom_range(1) ? -v : v;
  endfunction

  // One sample request; called on a falling edge, returns on one
  task automatic put_sample(input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az, input logic [16:0] rx,
                            input logic [16:0] ry, input logic [16:0] rz,
                            input logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {5'd0, stamp, rz, ry, rx, az, ay, ax};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every status is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Sample of a given motion shape, dt ms after the previous one
  task automatic send_motion(input motion_t m, input logic [31:0] dt);
    int ax, ay, az, rx, ry, rz;
    logic [31:0] stamp;
    clock_ms = clock_ms + dt;
    stamp    = clock_ms;
    rx = spread(200);
    ry = spread(200);
    rz = spread(200);
    ax = spread(100);
    ay = spread(100);
    az = signed_mag(850, 1150);
    case (m)
      SHAPE_STILL: begin
        ax = spread(150);
        ay = spread(150);
        az = spread(150);
      end
      SHAPE_LYING: begin
        ax = spread(280);
        ay = spread(280);
        az = spread(280);
      end
      SHAPE_UPRIGHT: ;
      SHAPE_FIDGET: rx = signed_mag(600, 1800);
      SHAPE_WALK: begin
        ax = spread(200);
        ay = spread(200);
        az = signed_mag(1550, 2900);
        rx = signed_mag(2100, 6000);
        ry = spread(1000);
      end
      SHAPE_IMPACT: begin
        ax = signed_mag(2000, 32768);
        ay = signed_mag(2000, 32768);
        az = signed_mag(2000, 32768);
      end
      default: begin
        // any bit pattern, rates sometimes past the nominal range
        ax = $urandom();
        ay = $urandom();
        az = $urandom();
        if ($urandom_range(1)) begin
          rx = $urandom();
          ry = $urandom();
          rz = $urandom();
        end else begin
          rx = spread(40000);
          ry = spread(40000);
          rz = spread(40000);
        end
        stamp    = $urandom();
        clock_ms = stamp;
      end
    endcase
    put_sample(ax[15:0], ay[15:0], az[15:0], rx[16:0], ry[16:0], rz[16:0], stamp);
  endtask

  // Mostly well-formed walking and fall sequences, some noise
  task automatic run_random(input int count);
    int goal, pick, n, i;
    logic [31:0] still_dt;
    goal = sent + count;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(2000);
      still_dt = (cur_still > 4000) ? 20 + $urandom_range(2000)
                                    : cur_still / 4 + 1 + $urandom_range(3);
      if (pick < 40) begin
        // walk, impact, still or walking samples around the window, maybe get up again
        n = $urandom_range(6, 3);
        for (i = 0; i < n; i++) send_motion(SHAPE_WALK, 20 + $urandom_range(cur_gap + 100));
        n = $urandom_range(2, 1);
        for (i = 0; i < n; i++) send_motion(SHAPE_IMPACT, 20);
        n = $urandom_range(9, 4);
        for (i = 0; i < n; i++)
          send_motion($urandom_range(1) ? SHAPE_STILL : SHAPE_WALK, still_dt);
        if ($urandom_range(1)) begin
          n = $urandom_range(3, 1);
          for (i = 0; i < n; i++) send_motion(SHAPE_UPRIGHT, still_dt);
        end
      end else if (pick < 70) begin
        // walking, gaps around the step gap
        n = $urandom_range(15, 5);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0)
            send_motion(SHAPE_FIDGET, 20);
          else if ($urandom_range(1))
            send_motion(SHAPE_WALK, cur_gap + $urandom_range(2));
          else
            send_motion(SHAPE_WALK, $urandom_range(cur_gap * 2 + 40));
        end
      end else if (pick < 85) begin
        n = $urandom_range(10, 4);
        for (i = 0; i < n; i++)
          send_motion(motion_t'($urandom_range(SHAPE_WALK, SHAPE_STILL)), 20);
      end else begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) send_motion(SHAPE_NOISE, 0);
      end
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  // Stimulus
  initial begin
    int phase;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent           = 0;
    clock_ms       = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, 3 g impact threshold, 30 s stillness, 500 ms gap
    put_sample(0, 0, 0, 0, 0, 0, 0);                        // lying, zero vector
    put_sample(32767, 32767, 32767, 0, 0, 0, 20);           // impact, level saturates
    put_sample(-32768, -32768, -32768, 0, 0, 0, 40);
    put_sample(0, 0, 1000, 40000, -40000, 40000, 60);       // rate extremes
    put_sample(0, 0, 1000, 17'h10000, 17'h0FFFF, 17'h1FFFF, 80); // rates past range
    put_sample(0, 0, 3000, 0, 0, 0, 100);                   // exactly at threshold
    put_sample(0, 0, 3001, 0, 0, 0, 120);                   // just over, arms
    put_sample(0, 0, 1600, 3000, 0, 0, 700);                // walking, step
    put_sample(0, 0, 1600, 3000, 0, 0, 1200);               // gap equal, no step
    put_sample(0, 0, 1600, 3000, 0, 0, 1201);               // gap exceeded, step
    put_sample(0, 0, 1000, 1000, 0, 0, 1220);               // fidgeting
    put_sample(0, 0, 1000, 200, 0, 0, 1240);                // standing band, shadowed
    put_sample(0, 0, 500, 0, 0, 0, 1260);                   // lying edge
    put_sample(0, 0, -499, 0, 0, 0, 1280);
    put_sample(0, 0, 100, 0, 0, 0, 31300);                  // still past window: confirm
    put_sample(0, 0, 1600, 3000, 0, 0, 31400);              // confirms again, no step
    put_sample(0, 0, 1000, 0, 0, 0, 31420);                 // movement cancels
    put_sample(0, 0, -4000, 0, 0, 0, 32'hFFFF_FF00);        // impact just before wrap
    put_sample(0, 0, 0, 0, 0, 0, 32'h0000_7600);            // confirm across wrap
    put_sample(0, 0, 2000, -2500, 0, 0, 32'h0000_7700);
    put_sample(0, 0, 1000, 0, 0, 0, 32'h0000_7800);
    put_sample(0, 0, 1600, 3000, 0, 0, 32'hFFFF_FFFF);      // step, time at maximum
    put_sample(0, 0, 1600, 3000, 0, 0, 32'h0000_0300);      // step across wrap

    // random phases: register settings and idling patterns
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: begin cur_thr = 8'd20;  cur_still = 32'd200;       cur_gap = 16'd100;    end
        1: begin cur_thr = 8'd0;   cur_still = 32'd0;         cur_gap = 16'd0;      end
        2: begin cur_thr = 8'd255; cur_still = 32'hFFFF_FFFF; cur_gap = 16'hFFFF;   end
        3: begin cur_thr = 8'd30;  cur_still = 32'd1000;      cur_gap = 16'd500;    end
        4: begin
          cur_thr   = $urandom_range(60, 10);
          cur_still = $urandom_range(3000);
          cur_gap   = $urandom_range(1000);
        end
        default: begin cur_thr = 8'd12; cur_still = 32'd60; cur_gap = 16'd40; end
      endcase
      write_reg(REG_IMPACT_THR, {24'd0, cur_thr});
      write_reg(REG_STILLNESS, cur_still);
      write_reg(REG_STEP_GAP, {16'd0, cur_gap});
      if (phase == 0) write_reg(REG_UNUSED, $urandom());
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      run_random(150);
    end

    // drain, then a margin past the block's latency
    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/imu_afd_pkg.sv
rtl/imu_afd_isqrt.sv
rtl/imu_activity_fall_detector_core.sv
sim/imu_afd_checker.sv
sim/testbench.sv
